/* hw/rtl/frag_rx_pkg.sv */
package frag_rx_pkg;

    localparam int MAX_FRAGMENTS = 4096;
    localparam int MAX_DATAGRAM  = 2048;

    localparam int DATA_W   = 8;
    localparam int FIELD_W  = 16;
    localparam int FRAG_W   = 13;
    localparam int INDEX_W  = 11;
    localparam int FB_W     = 11;
    localparam int OFFSET_W = 22;
    localparam int KIND_W   = 3;
    localparam int TDATA_W  = 48;

    localparam int FRAG_LIMIT  = (MAX_FRAGMENTS > 8191) ? 8191 : MAX_FRAGMENTS;
    localparam int PAYLOAD_CAP = (MAX_DATAGRAM - 1 > 2047) ? 2047 : MAX_DATAGRAM - 1;

    localparam logic [FB_W-1:0]    FB_RESET     = 11'd1000;
    localparam logic [DATA_W-1:0]  COLON        = 8'h3A;
    localparam logic [DATA_W-1:0]  NUL          = 8'h00;
    localparam logic [DATA_W-1:0]  DIGIT_ZERO   = 8'h30;
    localparam logic [DATA_W-1:0]  DIGIT_NINE   = 8'h39;
    localparam logic [FIELD_W-1:0] FIELD_MAX    = 16'hFFFF;
    localparam logic [FRAG_W-1:0]  FRAG_NUM_MAX = 13'h1FFF;

    localparam logic [KIND_W-1:0] KIND_NAME    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACK     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DUP     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NACK    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_INVALID = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SIZE    = 3'd6;

    typedef enum logic [2:0] {
        PH_TOTAL,
        PH_FRAG,
        PH_SIZE,
        PH_NAME,
        PH_PAYLOAD,
        PH_DISCARD
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [DATA_W-1:0]   byte_value;
        logic [OFFSET_W-1:0] file_offset;
        logic [FRAG_W-1:0]   fragment_number;
        logic                file_done;
    } result_t;

endpackage

/* hw/rtl/fragment_receiver_with_ack_core.sv */
// Fragment receiver core.
// The s_ channel takes one datagram byte per item in s_tdata; s_tlast marks the
// final byte of a datagram of the form total:frag:size:name:payload.
// The m_ channel gives at most one result item per input byte: m_tuser holds the
// kind, m_tdata the byte, file offset and fragment number, and m_tlast flags the
// item that completes the file.
// The fragment length for all but the last fragment is set through cfg_we and
// cfg_wdata while no item is in flight.
// A result passes from the input register, where the accepted item waits, to the output
// register, written by the parse and header check, and can be taken from there.
// Throughput is one item per cycle while the skid register is empty, set by the per-byte
// update of the parser state and the payload offset multiply-add.
// When the receiver stalls, a one-entry skid register takes the next result and
// s_tready drops once the skid register is full and the input register holds an item.
// Reset clears the parser, the session and both output stages, and sets the
// fragment length to 1000.
module fragment_receiver_with_ack_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // byte_value, file_offset, fragment_number, zero fill
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata
);

    logic                                 in_valid_reg, in_valid_next;
    logic [frag_rx_pkg::DATA_W-1:0]       in_byte_reg;
    logic                                 in_last_reg;

    logic [frag_rx_pkg::FB_W-1:0]         fb_reg;

    frag_rx_pkg::phase_t                  phase_reg, phase_next;
    logic [frag_rx_pkg::FIELD_W-1:0]      total_reg, total_next;
    logic [frag_rx_pkg::FIELD_W-1:0]      frag_reg, frag_next;
    logic [frag_rx_pkg::FIELD_W-1:0]      size_reg, size_next;
    logic                                 frozen_reg, frozen_next;
    logic                                 name_seen_reg, name_seen_next;
    logic                                 active_reg, active_next;
    logic [frag_rx_pkg::FRAG_W-1:0]       sess_total_reg, sess_total_next;
    logic [frag_rx_pkg::FRAG_W-1:0]       last_in_order_reg, last_in_order_next;
    logic [frag_rx_pkg::INDEX_W-1:0]      idx_reg, idx_next;
    logic                                 writing_reg, writing_next;

    logic                                 out_valid_reg, out_valid_next;
    frag_rx_pkg::result_t                 out_reg, out_next;
    logic                                 skid_valid_reg, skid_valid_next;
    frag_rx_pkg::result_t                 skid_reg, skid_next;

    logic                                 advance;
    logic                                 pop;
    logic                                 res_valid;
    frag_rx_pkg::result_t                 res;

    logic                                 is_digit;
    logic [frag_rx_pkg::FIELD_W-1:0]      acc_src;
    logic [19:0]                          acc_wide;
    logic [frag_rx_pkg::FIELD_W-1:0]      acc_value;

    logic                                 hdr_valid;
    logic [frag_rx_pkg::FRAG_W-1:0]       eff_total;
    logic [frag_rx_pkg::FRAG_W-1:0]       eff_last;
    logic [frag_rx_pkg::FRAG_W:0]         eff_last_inc;
    logic [frag_rx_pkg::FRAG_W-1:0]       frag_number;

    logic [frag_rx_pkg::INDEX_W:0]        idx_ext;
    logic [frag_rx_pkg::INDEX_W:0]        idx_inc;
    logic                                 pay_in_range;
    logic                                 pay_last;
    logic [frag_rx_pkg::FRAG_W-1:0]       frag_m1;
    logic [23:0]                          product;
    logic [23:0]                          offset_sum;

    assign pop      = out_valid_reg && m_tready;
    assign advance  = in_valid_reg && !skid_valid_reg;
    assign s_tready = !in_valid_reg || !skid_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.file_done;
    assign m_tdata  = {5'd0, out_reg.fragment_number, out_reg.file_offset,
                       out_reg.byte_value};

    // Decimal accumulation with saturation.
    assign is_digit = (in_byte_reg >= frag_rx_pkg::DIGIT_ZERO) &&
                      (in_byte_reg <= frag_rx_pkg::DIGIT_NINE);

    always_comb begin
        case (phase_reg)
            frag_rx_pkg::PH_TOTAL: acc_src = total_reg;
            frag_rx_pkg::PH_FRAG:  acc_src = frag_reg;
            default:               acc_src = size_reg;
        endcase
    end

    assign acc_wide  = {acc_src, 3'd0} + {3'd0, acc_src, 1'b0} +
                       20'(in_byte_reg - frag_rx_pkg::DIGIT_ZERO);
    assign acc_value = (frozen_reg || !is_digit) ? acc_src :
                       (acc_wide > 20'(frag_rx_pkg::FIELD_MAX)) ? frag_rx_pkg::FIELD_MAX :
                       acc_wide[frag_rx_pkg::FIELD_W-1:0];

    // Header check.
    assign hdr_valid = name_seen_reg &&
                       (total_reg >= 16'd1) &&
                       (total_reg <= 16'(frag_rx_pkg::FRAG_LIMIT)) &&
                       (frag_reg >= 16'd1) &&
                       (frag_reg <= total_reg) &&
                       (!active_reg || (frag_reg <= 16'(sess_total_reg)));
    assign eff_total    = active_reg ? sess_total_reg : total_reg[frag_rx_pkg::FRAG_W-1:0];
    assign eff_last     = active_reg ? last_in_order_reg : '0;
    assign eff_last_inc = {1'b0, eff_last} + 14'd1;
    assign frag_number  = (frag_reg > 16'(frag_rx_pkg::FRAG_NUM_MAX)) ?
                          frag_rx_pkg::FRAG_NUM_MAX : frag_reg[frag_rx_pkg::FRAG_W-1:0];

    // Payload position.
    assign idx_ext      = {1'b0, idx_reg};
    assign idx_inc      = idx_ext + 12'd1;
    assign pay_in_range = (16'(idx_reg) < size_reg) &&
                          (idx_ext < 12'(frag_rx_pkg::PAYLOAD_CAP));
    assign pay_last     = (16'(idx_inc) >= size_reg) ||
                          (idx_inc >= 12'(frag_rx_pkg::PAYLOAD_CAP)) || in_last_reg;
    assign frag_m1      = frag_reg[frag_rx_pkg::FRAG_W-1:0] - 13'd1;
    assign product      = 24'(frag_m1) * 24'(fb_reg);
    assign offset_sum   = product + 24'(idx_reg);

    always_comb begin
        phase_next         = phase_reg;
        total_next         = total_reg;
        frag_next          = frag_reg;
        size_next          = size_reg;
        frozen_next        = frozen_reg;
        name_seen_next     = name_seen_reg;
        active_next        = active_reg;
        sess_total_next    = sess_total_reg;
        last_in_order_next = last_in_order_reg;
        idx_next           = idx_reg;
        writing_next       = writing_reg;
        res_valid          = 1'b0;
        res                = '0;
        res.fragment_number = frag_number;

        if (advance) begin
            if (phase_reg inside {frag_rx_pkg::PH_TOTAL, frag_rx_pkg::PH_FRAG,
                                  frag_rx_pkg::PH_SIZE, frag_rx_pkg::PH_NAME}) begin
                if ((in_byte_reg == frag_rx_pkg::NUL) ||
                    (in_last_reg && !(phase_reg == frag_rx_pkg::PH_NAME &&
                                      in_byte_reg == frag_rx_pkg::COLON))) begin
                    active_next        = 1'b0;
                    sess_total_next    = '0;
                    last_in_order_next = '0;
                    res_valid          = 1'b1;
                    res.kind           = frag_rx_pkg::KIND_INVALID;
                    phase_next         = frag_rx_pkg::PH_DISCARD;
                end else if (phase_reg == frag_rx_pkg::PH_NAME) begin
                    res_valid = 1'b1;
                    if (in_byte_reg == frag_rx_pkg::COLON) begin
                        phase_next = frag_rx_pkg::PH_DISCARD;
                        if (!hdr_valid) begin
                            active_next        = 1'b0;
                            sess_total_next    = '0;
                            last_in_order_next = '0;
                            res.kind           = frag_rx_pkg::KIND_INVALID;
                        end else begin
                            active_next     = 1'b1;
                            sess_total_next = eff_total;
                            last_in_order_next = eff_last;
                            if (frag_reg <= 16'(eff_last)) begin
                                res.kind = frag_rx_pkg::KIND_DUP;
                            end else if (frag_reg != 16'(eff_last_inc)) begin
                                res.kind = frag_rx_pkg::KIND_NACK;
                            end else if ((frag_reg != 16'(eff_total)) &&
                                         (size_reg != 16'(fb_reg))) begin
                                active_next        = 1'b0;
                                sess_total_next    = '0;
                                last_in_order_next = '0;
                                res.kind           = frag_rx_pkg::KIND_SIZE;
                            end else begin
                                res.kind           = frag_rx_pkg::KIND_ACK;
                                phase_next         = frag_rx_pkg::PH_PAYLOAD;
                                idx_next           = '0;
                                writing_next       = (size_reg != '0) && !in_last_reg;
                                last_in_order_next =
                                    eff_last_inc[frag_rx_pkg::FRAG_W-1:0];
                                if (!writing_next &&
                                    (eff_last_inc[frag_rx_pkg::FRAG_W-1:0] == eff_total)) begin
                                    active_next        = 1'b0;
                                    sess_total_next    = '0;
                                    last_in_order_next = '0;
                                    res.file_done      = 1'b1;
                                end
                            end
                        end
                    end else begin
                        name_seen_next = 1'b1;
                        res.kind       = frag_rx_pkg::KIND_NAME;
                        res.byte_value = in_byte_reg;
                    end
                end else if (in_byte_reg == frag_rx_pkg::COLON) begin
                    frozen_next = 1'b0;
                    case (phase_reg)
                        frag_rx_pkg::PH_TOTAL: phase_next = frag_rx_pkg::PH_FRAG;
                        frag_rx_pkg::PH_FRAG:  phase_next = frag_rx_pkg::PH_SIZE;
                        default:               phase_next = frag_rx_pkg::PH_NAME;
                    endcase
                end else begin
                    frozen_next = frozen_reg || !is_digit;
                    case (phase_reg)
                        frag_rx_pkg::PH_TOTAL: total_next = acc_value;
                        frag_rx_pkg::PH_FRAG:  frag_next  = acc_value;
                        default:               size_next  = acc_value;
                    endcase
                end
            end else if (phase_reg == frag_rx_pkg::PH_PAYLOAD && writing_reg) begin
                if (pay_in_range) begin
                    res_valid       = 1'b1;
                    res.kind        = frag_rx_pkg::KIND_PAYLOAD;
                    res.byte_value  = in_byte_reg;
                    res.file_offset = offset_sum[frag_rx_pkg::OFFSET_W-1:0];
                    idx_next        = idx_inc[frag_rx_pkg::INDEX_W-1:0];
                    if (pay_last) begin
                        writing_next = 1'b0;
                        if (active_reg && (last_in_order_reg == sess_total_reg)) begin
                            res.file_done      = 1'b1;
                            active_next        = 1'b0;
                            sess_total_next    = '0;
                            last_in_order_next = '0;
                        end
                    end
                end else begin
                    writing_next = 1'b0;
                end
            end

            if (in_last_reg) begin
                phase_next     = frag_rx_pkg::PH_TOTAL;
                total_next     = '0;
                frag_next      = '0;
                size_next      = '0;
                frozen_next    = 1'b0;
                name_seen_next = 1'b0;
                idx_next       = '0;
                writing_next   = 1'b0;
            end
        end
    end

    always_comb begin
        in_valid_next   = in_valid_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        if (skid_valid_reg) begin
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || pop) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= (s_tvalid && s_tready) ? s_tdata : in_byte_reg;
        in_last_reg <= (s_tvalid && s_tready) ? s_tlast : in_last_reg;
        out_reg     <= out_next;
        skid_reg    <= skid_next;
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
            fb_reg            <= frag_rx_pkg::FB_RESET;
            phase_reg         <= frag_rx_pkg::PH_TOTAL;
            total_reg         <= '0;
            frag_reg          <= '0;
            size_reg          <= '0;
            frozen_reg        <= 1'b0;
            name_seen_reg     <= 1'b0;
            active_reg        <= 1'b0;
            sess_total_reg    <= '0;
            last_in_order_reg <= '0;
            idx_reg           <= '0;
            writing_reg       <= 1'b0;
        end else begin
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
            fb_reg            <= cfg_we ? cfg_wdata : fb_reg;
            phase_reg         <= phase_next;
            total_reg         <= total_next;
            frag_reg          <= frag_next;
            size_reg          <= size_next;
            frozen_reg        <= frozen_next;
            name_seen_reg     <= name_seen_next;
            active_reg        <= active_next;
            sess_total_reg    <= sess_total_next;
            last_in_order_reg <= last_in_order_next;
            idx_reg           <= idx_next;
            writing_reg       <= writing_next;
        end
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while the output register is empty");

    a_writing_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        writing_reg |-> (phase_reg == frag_rx_pkg::PH_PAYLOAD))
        else $error("payload write active outside the payload phase");

    a_session_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (sess_total_reg != '0) && (last_in_order_reg <= sess_total_reg))
        else $error("session fragment count out of range");

    a_done_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
            (m_tuser == frag_rx_pkg::KIND_PAYLOAD) || (m_tuser == frag_rx_pkg::KIND_ACK))
        else $error("file completion flagged on an item that is neither payload nor ack");

endmodule

/* sim/fragment_receiver_with_ack_core_test.sv */
`timescale 1ns / 100ps

module fragment_receiver_with_ack_core_test;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS = 100;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;

    fragment_receiver_with_ack_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver-side state of the datagram parser and the file session.
    frag_rx_pkg::phase_t rx_phase;
    logic [15:0] total_acc;
    logic [15:0] frag_acc;
    logic [15:0] size_acc;
    bit          frozen;
    bit          have_name;
    bit          in_session;
    logic [12:0] sess_total;
    logic [12:0] in_order;
    logic [12:0] stored;
    logic [10:0] pay_idx;
    bit          pay_active;
    logic [10:0] frag_len;

    frag_rx_pkg::result_t expected_replies[$];
    logic [7:0]  dgram[$];

    int sender_gap_pct = 0;
    int recv_stall_pct = 0;
    int holdoff_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int items_sent = 0;
    int useful_items = 0;
    int checked_results = 0;
    int files_done = 0;

    function automatic void reset_packet_state();
        rx_phase = frag_rx_pkg::PH_TOTAL;
        total_acc = '0;
        frag_acc = '0;
        size_acc = '0;
        frozen = 1'b0;
        have_name = 1'b0;
        pay_idx = '0;
        pay_active = 1'b0;
    endfunction

    function automatic void drop_session();
        in_session = 1'b0;
        sess_total = '0;
        in_order = '0;
        stored = '0;
    endfunction

    function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] b);
        int v;
        v = int'(acc);
        if (!frozen) begin
            if (b < frag_rx_pkg::DIGIT_ZERO || b > frag_rx_pkg::DIGIT_NINE) begin
                frozen = 1'b1;
            end else begin
                v = v * 10 + int'(b - frag_rx_pkg::DIGIT_ZERO);
                if (v > int'(frag_rx_pkg::FIELD_MAX)) v = int'(frag_rx_pkg::FIELD_MAX);
            end
        end
        return v[15:0];
    endfunction

    function automatic frag_rx_pkg::result_t result_of(input logic [2:0] kind,
                                                       input logic [7:0] b,
                                                       input logic [21:0] off,
                                                       input bit done);
        frag_rx_pkg::result_t r;
        r.kind = kind;
        r.byte_value = b;
        r.file_offset = off;
        r.fragment_number = (frag_acc > frag_rx_pkg::FRAG_NUM_MAX) ?
                            frag_rx_pkg::FRAG_NUM_MAX : frag_acc[12:0];
        r.file_done = done;
        return r;
    endfunction

    function automatic frag_rx_pkg::result_t header_verdict(input bit eop);
        bit ok;
        ok = have_name && total_acc >= 1 && total_acc <= frag_rx_pkg::MAX_FRAGMENTS
             && total_acc <= frag_rx_pkg::FRAG_NUM_MAX && frag_acc >= 1
             && frag_acc <= total_acc && (!in_session || frag_acc <= sess_total);
        rx_phase = frag_rx_pkg::PH_DISCARD;
        if (!ok) begin
            drop_session();
            return result_of(frag_rx_pkg::KIND_INVALID, 8'h00, 22'h0, 1'b0);
        end
        if (!in_session) begin
            in_session = 1'b1;
            sess_total = total_acc[12:0];
            in_order = '0;
            stored = '0;
        end
        if (frag_acc <= in_order) return result_of(frag_rx_pkg::KIND_DUP, 8'h00, 22'h0, 1'b0);
        if (frag_acc != in_order + 1) begin
            return result_of(frag_rx_pkg::KIND_NACK, 8'h00, 22'h0, 1'b0);
        end
        if (frag_acc != sess_total && size_acc != frag_len) begin
            drop_session();
            return result_of(frag_rx_pkg::KIND_SIZE, 8'h00, 22'h0, 1'b0);
        end
        in_order = in_order + 1'b1;
        stored = stored + 1'b1;
        rx_phase = frag_rx_pkg::PH_PAYLOAD;
        pay_idx = '0;
        pay_active = (size_acc != 0) && !eop;
        if (!pay_active && stored == sess_total) begin
            drop_session();
            return result_of(frag_rx_pkg::KIND_ACK, 8'h00, 22'h0, 1'b1);
        end
        return result_of(frag_rx_pkg::KIND_ACK, 8'h00, 22'h0, 1'b0);
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input bit eop,
                                      output frag_rx_pkg::result_t r);
        bit got;
        bit last;
        bit done;
        int off;
        got = 1'b0;
        r = '0;
        if (rx_phase <= frag_rx_pkg::PH_NAME) begin
            if (b == frag_rx_pkg::NUL ||
                (eop && !(rx_phase == frag_rx_pkg::PH_NAME && b == frag_rx_pkg::COLON))) begin
                drop_session();
                r = result_of(frag_rx_pkg::KIND_INVALID, 8'h00, 22'h0, 1'b0);
                rx_phase = frag_rx_pkg::PH_DISCARD;
                got = 1'b1;
            end else if (rx_phase == frag_rx_pkg::PH_NAME) begin
                if (b == frag_rx_pkg::COLON) begin
                    r = header_verdict(eop);
                end else begin
                    have_name = 1'b1;
                    r = result_of(frag_rx_pkg::KIND_NAME, b, 22'h0, 1'b0);
                end
                got = 1'b1;
            end else if (b == frag_rx_pkg::COLON) begin
                rx_phase = frag_rx_pkg::phase_t'(rx_phase + 3'd1);
                frozen = 1'b0;
            end else if (rx_phase == frag_rx_pkg::PH_TOTAL) begin
                total_acc = add_digit(total_acc, b);
            end else if (rx_phase == frag_rx_pkg::PH_FRAG) begin
                frag_acc = add_digit(frag_acc, b);
            end else begin
                size_acc = add_digit(size_acc, b);
            end
        end else if (rx_phase == frag_rx_pkg::PH_PAYLOAD && pay_active) begin
            if (pay_idx < size_acc && pay_idx < frag_rx_pkg::PAYLOAD_CAP) begin
                off = (int'(frag_acc) - 1) * int'(frag_len) + int'(pay_idx);
                last = (int'(pay_idx) + 1 >= int'(size_acc))
                       || (int'(pay_idx) + 1 >= frag_rx_pkg::PAYLOAD_CAP) || eop;
                done = last && in_session && stored == sess_total;
                pay_idx = pay_idx + 1'b1;
                if (last) pay_active = 1'b0;
                if (done) drop_session();
                r = result_of(frag_rx_pkg::KIND_PAYLOAD, b, off[21:0], done);
                got = 1'b1;
            end else begin
                pay_active = 1'b0;
            end
        end
        if (eop) reset_packet_state();
        return got;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit eop);
        int gap;
        bit header_byte;
        frag_rx_pkg::result_t r;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_gap_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eop;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        header_byte = (rx_phase <= frag_rx_pkg::PH_NAME);
        if (parse_byte(b, eop, r)) begin
            expected_replies.push_back(r);
            useful_items++;
        end else if (header_byte) begin
            useful_items++;
        end
        items_sent++;
    endtask

    task automatic send_dgram();
        for (int i = 0; i < dgram.size(); i++) send_byte(dgram[i], i == dgram.size() - 1);
    endtask

    task automatic add_text(input string txt);
        for (int i = 0; i < txt.len(); i++) dgram.push_back(txt[i]);
    endtask

    task automatic add_name(input int n);
        logic [7:0] c;
        repeat (n) begin
            do c = 8'($urandom_range(1, 255)); while (c == frag_rx_pkg::COLON);
            dgram.push_back(c);
        end
    endtask

    task automatic add_payload(input int n);
        repeat (n) dgram.push_back(8'($urandom_range(255)));
    endtask

    task automatic send_text(input string hdr, input int plen);
        dgram.delete();
        add_text(hdr);
        add_payload(plen);
        send_dgram();
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic set_fragment_bytes(input logic [10:0] value);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        frag_len = value;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_gap_pct = sender_pct;
        recv_stall_pct <= receiver_pct;
    endtask

    function automatic string num_text(input int v);
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) return $sformatf("00%0d", v);
        if (pick == 1) return $sformatf("%0dz", v);
        return $sformatf("%0d", v);
    endfunction

    task automatic send_fragment(input int total, input int frag, input int size, input int plen);
        int roll;
        int keep;
        dgram.delete();
        add_text($sformatf("%s:%s:%s:", num_text(total), num_text(frag), num_text(size)));
        add_name($urandom_range(1, 3));
        add_text(":");
        add_payload(plen);
        roll = $urandom_range(99);
        if (roll < 4) begin
            dgram[$urandom_range(dgram.size() - 1)] = 8'($urandom_range(255));
        end else if (roll < 7) begin
            keep = $urandom_range(1, dgram.size());
            dgram = dgram[0:keep-1];
        end
        send_dgram();
    endtask

    task automatic send_noise();
        int len;
        len = $urandom_range(1, 10);
        dgram.delete();
        repeat (len) begin
            case ($urandom_range(3))
                0: dgram.push_back(frag_rx_pkg::COLON);
                1: dgram.push_back(8'(frag_rx_pkg::DIGIT_ZERO + $urandom_range(9)));
                default: dgram.push_back(8'($urandom_range(255)));
            endcase
        end
        send_dgram();
    endtask

    task automatic random_transfer();
        int total;
        int frag;
        int size;
        int plen;
        int roll;
        total = ($urandom_range(9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
        frag = 1;
        while (frag <= total) begin
            roll = $urandom_range(99);
            if (roll < 8 && frag > 1) begin
                send_fragment(total, $urandom_range(1, frag - 1), frag_len, frag_len);
            end else if (roll < 14 && frag < total) begin
                send_fragment(total, $urandom_range(frag + 1, total), frag_len, frag_len);
            end else if (roll < 18) begin
                send_noise();
            end else if (roll < 21 && frag < total) begin
                size = ($urandom_range(1) == 0 || frag_len == 0) ? frag_len + 1 : frag_len - 1;
                send_fragment(total, frag, size, $urandom_range(0, 3));
                return;
            end else begin
                size = (frag == total) ? $urandom_range(0, frag_len + 2) : frag_len;
                plen = ($urandom_range(9) == 0) ? $urandom_range(0, size + 3) : size;
                send_fragment(total, frag, size, plen);
                frag++;
            end
        end
    endtask

    task automatic test_header_checks();
        set_idling(0, 0);
        dgram.delete();
        add_text("1:");
        dgram.push_back(frag_rx_pkg::NUL);
        add_text("1:0:n:x");
        send_dgram();
        send_text("2:1:5:ab", 0);
        send_text("2:3:1000:f:", 0);
        send_text("0:1:0:z:", 0);
        send_text("4097:1:0:z:", 0);
        send_text("99999999:1:0:z:", 0);
        send_text("5:70000:1:q:", 0);
        send_text("1:1:0::", 0);
        send_text("x5:1:0:k:", 0);
        send_text("1x9:1:0:k:", 0);
        send_text("4096:1:1000:w:", 3);
        send_text("3:5:1:w:", 0);
        dgram.delete();
        add_text("1:1:0:");
        dgram.push_back(8'hFF);
        add_text(":");
        send_dgram();
        wait_results_done();
    endtask

    task automatic test_fragment_order();
        set_fragment_bytes(11'd2);
        send_text("3:1:2:a:", 2);
        send_text("3:1:2:a:", 2);
        send_text("3:3:1:a:", 1);
        send_text("3:2:1:a:", 1);
        send_text("3:1:2:ab:", 2);
        send_text("3:2:2:ab:", 4);
        send_text("3:3:5:ab:", 0);
        send_text("2:1:2:c:", 2);
        send_text("2:2:0:c:", 0);
        send_text("2:1:2:c:", 2);
        send_text("2:2:4:c:", 1);
        send_text("2:1:2:c:", 2);
        send_text("5:4:2:c:", 2);
        wait_results_done();
    endtask

    task automatic test_length_change();
        set_fragment_bytes(11'd3);
        send_text("3:1:3:n:", 3);
        set_fragment_bytes(11'd5);
        send_text("3:2:5:n:", 5);
        set_fragment_bytes(11'd1024);
        send_text("3:3:2:n:", 2);
        wait_results_done();
    endtask

    task automatic test_payload_limits();
        set_fragment_bytes(11'd20);
        send_text("2:1:20:lim:", 23);
        send_text("2:2:30:lim:", 25);
        set_fragment_bytes(11'd1);
        send_text("3:1:1:o:", 1);
        send_text("3:2:1:o:", 1);
        send_text("3:3:0:o:", 0);
        wait_results_done();
    endtask

    task automatic test_backpressure();
        set_fragment_bytes(11'd4);
        set_idling(0, 0);
        holdoff_left <= 300;
        dgram.delete();
        add_text("2:1:4:");
        add_name(24);
        add_text(":");
        add_payload(4);
        send_dgram();
        wait_results_done();
        send_text("2:2:3:tail:", 3);
        wait_results_done();
    endtask

    task automatic random_phase(input int sender_pct, input int receiver_pct,
                                input logic [10:0] len);
        int start;
        set_fragment_bytes(len);
        set_idling(sender_pct, receiver_pct);
        start = useful_items;
        while (useful_items - start < PHASE_ITEMS) random_transfer();
        wait_results_done();
    endtask

    task automatic test_random_traffic();
        random_phase(0, 0, 11'd1);
        random_phase(73, 0, 11'($urandom_range(2, 6)));
        random_phase(0, 73, 11'd3);
        random_phase(13, 13, 11'($urandom_range(1, 8)));
        set_idling(0, 0);
    endtask

    always @(posedge aclk) begin
        if (holdoff_left > 0) begin
            m_tready <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        frag_rx_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                $error("result item with none expected: kind %0d", m_tuser);
                fail_count++;
            end else begin
                want = expected_replies.pop_front();
                if (m_tuser !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                    fail_count++;
                end
                if (m_tdata[7:0] !== want.byte_value) begin
                    $error("byte_value: expected %0d, got %0d", want.byte_value, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[29:8] !== want.file_offset) begin
                    $error("file_offset: expected %0d, got %0d", want.file_offset,
                           m_tdata[29:8]);
                    fail_count++;
                end
                if (m_tdata[42:30] !== want.fragment_number) begin
                    $error("fragment_number: expected %0d, got %0d", want.fragment_number,
                           m_tdata[42:30]);
                    fail_count++;
                end
                if (m_tlast !== want.file_done) begin
                    $error("file_done: expected %0d, got %0d", want.file_done, m_tlast);
                    fail_count++;
                end
                if (m_tdata[47:43] !== 5'd0) begin
                    $error("tdata fill: expected 0, got %0d", m_tdata[47:43]);
                    fail_count++;
                end
                checked_results++;
                if (want.file_done) files_done++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("fragment_receiver_with_ack_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        frag_len = frag_rx_pkg::FB_RESET;
        reset_packet_state();
        drop_session();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_header_checks();
        test_fragment_order();
        test_length_change();
        test_payload_limits();
        test_backpressure();
        test_random_traffic();
        wait_results_done();
        repeat (20) @(posedge aclk);
        $display("Sent %0d input items, checked %0d result items, %0d completing a file.",
                 items_sent, checked_results, files_done);
        $display("Covered header errors, fragment order, payload limits, length changes %s",
                 "and back-pressure under four idling mixes.");
        if (fail_count == 0) begin
            $display("fragment_receiver_with_ack_core: match");
        end else begin
            $display("fragment_receiver_with_ack_core: mismatch");
        end
        $finish;
    end

endmodule
